### design/olid_pkg.sv
// ----------------------------------------------------------------------------
// olid_pkg
// Shared types and codes for the ordered list insert/delete block.
// ----------------------------------------------------------------------------
package olid_pkg;

  localparam int CAPACITY_DEF  = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int POS_BITS      = 5;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_GET    = 2'd2;
  localparam logic [1:0] CMD_LOCATE = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic        [1:0]          cmd;
    logic        [POS_BITS-1:0] position;
    logic signed [31:0]         value;
  } item_t;

  typedef struct packed {
    logic        [1:0]          status;
    logic signed [31:0]         read_value;
    logic        [POS_BITS-1:0] found_position;
    logic        [POS_BITS-1:0] count;
  } result_t;

  // broadcast to every cell; slot is the zero-based target position
  typedef struct packed {
    logic                ins;
    logic                del;
    logic [POS_BITS-1:0] slot;
  } cell_ctrl_t;

endpackage

### design/olid_cell.sv
// ----------------------------------------------------------------------------
// olid_cell
// One list entry: loads, shifts up from its left neighbor, shifts down from
// its right neighbor or holds; flags a match and a position hit.
// ----------------------------------------------------------------------------
module olid_cell
  import olid_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int CNT_W     = 5,
  parameter int INDEX     = 0
) (
  input  logic                 clk,
  input  cell_ctrl_t           ctrl,
  input  logic [WORD_BITS-1:0] key,
  input  logic [WORD_BITS-1:0] left_word,
  input  logic [WORD_BITS-1:0] right_word,
  input  logic [CNT_W-1:0]     count,
  output logic [WORD_BITS-1:0] word,
  output logic                 match,
  output logic                 at_slot
);

  logic [WORD_BITS-1:0] word_next;
  logic [31:0]          slot_ext;
  logic [31:0]          idx;

  assign slot_ext = 32'(ctrl.slot);
  assign idx      = 32'(INDEX);
  assign at_slot  = (slot_ext == idx);
  assign match    = (word == key) && (32'(count) > idx);

  always_comb begin
    word_next = word;
    if (ctrl.ins) begin
      if (slot_ext == idx) word_next = key;
      else if (slot_ext < idx) word_next = left_word;
    end else if (ctrl.del) begin
      if (slot_ext <= idx) word_next = right_word;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

### design/ordered_list_insert_delete.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_delete
// Bounded ordered list of words with insert, delete, get and locate.
// ----------------------------------------------------------------------------
// A command transfers at a rising edge with start high and busy low; busy
// stays low, so a command can be issued every cycle. Each command takes one
// cycle: its result appears on result with done high in the cycle after the
// transfer, for that one cycle only, and must be captured then. The list is a
// row of CAPACITY cells that all shift in the same cycle; locate compares
// every live cell at once and a priority encoder picks the first match.
// Positions count from 1. Stored words are not cleared at reset; only the
// entry count and done are.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete
  import olid_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = ((CNT_W > POS_BITS) ? CNT_W : POS_BITS) + 1;

  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     cnt_next;
  result_t              result_next;
  cell_ctrl_t           ctrl;
  logic                 xfer;
  logic [WORD_BITS-1:0] key;
  logic [WORD_BITS-1:0] words [CAPACITY];
  logic [CAPACITY-1:0]  match;
  logic [CAPACITY-1:0]  hit;
  logic [WORD_BITS-1:0] rd_word;
  logic [CNT_W-1:0]     found;
  logic [CW-1:0]        pos_w;
  logic [CW-1:0]        cnt_w;
  logic                 ins_range_err;
  logic                 full;
  logic                 rd_range_err;

  assign busy  = 1'b0;
  assign xfer  = start && !busy;
  assign key   = WORD_BITS'(item.value);
  assign pos_w = CW'(item.position);
  assign cnt_w = CW'(cnt);

  assign ins_range_err = (pos_w == '0) || (pos_w > cnt_w + CW'(1));
  assign full          = (cnt_w == CW'(CAPACITY));
  assign rd_range_err  = (pos_w == '0) || (pos_w > cnt_w);

  assign ctrl.slot = item.position - POS_BITS'(1);
  assign ctrl.ins  = xfer && (item.cmd == CMD_INSERT) && !ins_range_err && !full;
  assign ctrl.del  = xfer && (item.cmd == CMD_DELETE) && !rd_range_err;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    olid_cell #(
      .WORD_BITS(WORD_BITS),
      .CNT_W    (CNT_W),
      .INDEX    (k)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .key       (key),
      .left_word ((k == 0) ? words[k] : words[(k == 0) ? 0 : k - 1]),
      .right_word((k == CAPACITY - 1) ? words[k] : words[(k == CAPACITY - 1) ? k : k + 1]),
      .count     (cnt),
      .word      (words[k]),
      .match     (match[k]),
      .at_slot   (hit[k])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_word = rd_word | (words[k] & {WORD_BITS{hit[k]}});
    end
  end

  always_comb begin
    found = '0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (match[k]) found = CNT_W'(k + 1);
    end
  end

  always_comb begin
    cnt_next    = cnt;
    result_next = '0;
    unique case (item.cmd)
      CMD_INSERT: begin
        if (ins_range_err) result_next.status = ST_RANGE;
        else if (full) result_next.status = ST_FULL;
        else begin
          result_next.status = ST_OK;
          cnt_next           = cnt + CNT_W'(1);
        end
      end
      CMD_DELETE: begin
        if (rd_range_err) result_next.status = ST_RANGE;
        else begin
          result_next.status     = ST_OK;
          result_next.read_value = 32'(rd_word);
          cnt_next               = cnt - CNT_W'(1);
        end
      end
      CMD_GET: begin
        if (rd_range_err) result_next.status = ST_RANGE;
        else begin
          result_next.status     = ST_OK;
          result_next.read_value = 32'(rd_word);
        end
      end
      CMD_LOCATE: begin
        if (found != '0) begin
          result_next.status         = ST_OK;
          result_next.found_position = POS_BITS'(found);
        end else begin
          result_next.status = ST_NOTFOUND;
        end
      end
      default: result_next.status = ST_OK;
    endcase
    result_next.count = POS_BITS'(cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= xfer;
      if (xfer) cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) result <= result_next;
  end

`ifndef ASSERT_OFF
  a_done_follows_xfer: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("done without a command transfer");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) <= CAPACITY)
    else $error("entry count above capacity");

  a_err_keeps_cnt: assert property (@(posedge clk) disable iff (rst)
    done && (result.status != ST_OK) |-> cnt == $past(cnt))
    else $error("failed command changed the entry count");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    done && (result.found_position != '0) |-> result.status == ST_OK)
    else $error("found position with bad status");
`endif

endmodule

### verif/olid_list_checker.sv
// ----------------------------------------------------------------------------
// olid_list_checker
// Watches the command and result channels of the ordered list block, keeps
// its own copy of the list, works out the result of each accepted command and
// compares every strobed result, field by field, with the oldest one owed.
// ----------------------------------------------------------------------------
module olid_list_checker
  import olid_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  item_t   item,
  input  logic    done,
  input  result_t result,
  output int      failures,
  output int      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [31:0] shadow_words [CAPACITY_DEF];
  int                 shadow_len;
  result_t            owed_results [$];

  initial begin
    failures   = 0;
    pending    = 0;
    shadow_len = 0;
  end

  task automatic apply_command(input item_t cmd_in, output result_t res);
    int                 p;
    int                 k;
    int                 hit;
    logic signed [31:0] gone;
    p   = cmd_in.position;
    res = '0;
    case (cmd_in.cmd)
      CMD_INSERT: begin
        if (p < 1 || p > shadow_len + 1) begin
          res.status = ST_RANGE;
        end else if (shadow_len >= CAPACITY_DEF) begin
          res.status = ST_FULL;
        end else begin
          for (k = shadow_len; k >= p; k--) shadow_words[k] = shadow_words[k-1];
          shadow_words[p-1] = cmd_in.value;
          shadow_len++;
          res.status = ST_OK;
        end
      end
      CMD_DELETE: begin
        if (p < 1 || p > shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          gone = shadow_words[p-1];
          for (k = p; k < shadow_len; k++) shadow_words[k-1] = shadow_words[k];
          shadow_len--;
          res.status     = ST_OK;
          res.read_value = gone;
        end
      end
      CMD_GET: begin
        if (p < 1 || p > shadow_len) begin
          res.status = ST_RANGE;
        end else begin
          res.status     = ST_OK;
          res.read_value = shadow_words[p-1];
        end
      end
      default: begin
        hit = 0;
        for (k = 0; k < shadow_len; k++) begin
          if (hit == 0 && shadow_words[k] == cmd_in.value) hit = k + 1;
        end
        if (hit != 0) begin
          res.status         = ST_OK;
          res.found_position = hit[POS_BITS-1:0];
        end else begin
          res.status = ST_NOTFOUND;
        end
      end
    endcase
    res.count = shadow_len[POS_BITS-1:0];
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t fresh;
    bit      bad;
    if (rst) begin
      shadow_len = 0;
      owed_results.delete();
    end else begin
      if (done === 1'b1) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result with nothing owed, got status %0d count %0d",
                   $time, result.status, result.count);
          failures++;
        end else begin
          want = owed_results.pop_front();
          bad  = 0;
          if (result.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, result.status);
            bad = 1;
          end
          if (result.read_value !== want.read_value) begin
            $display("%0t: read_value mismatch, expected %0d, got %0d",
                     $time, want.read_value, result.read_value);
            bad = 1;
          end
          if (result.found_position !== want.found_position) begin
            $display("%0t: found_position mismatch, expected %0d, got %0d",
                     $time, want.found_position, result.found_position);
            bad = 1;
          end
          if (result.count !== want.count) begin
            $display("%0t: count mismatch, expected %0d, got %0d",
                     $time, want.count, result.count);
            bad = 1;
          end
          if (bad) failures++;
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        apply_command(item, fresh);
        owed_results.push_back(fresh);
      end
    end
    pending = owed_results.size();
  end

endmodule

### verif/tb_ordered_list_insert_delete.sv
// ----------------------------------------------------------------------------
// tb_ordered_list_insert_delete
// Drives directed and random insert, delete, get and locate commands into the
// ordered list block with random gaps, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_ordered_list_insert_delete;
  import olid_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_CMDS = 1850;
  localparam int QUIET_TAIL  = 300;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  item_t   item;
  logic    done;
  result_t result;
  int      failures;
  int      pending;
  int      seen_len;

  ordered_list_insert_delete dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  olid_list_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .done     (done),
    .result   (result),
    .failures (failures),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("%0t: timeout", $time);
    $display("FAILURE");
    $finish;
  end

  // list length as last reported, used only to steer positions
  always @(posedge clk) begin
    if (rst) begin
      seen_len <= 0;
    end else if (done === 1'b1) begin
      seen_len <= result.count;
    end
  end

  task automatic send_command(input logic [1:0] c, input int p, input logic [31:0] v);
    @(negedge clk);
    start         = 1'b1;
    item.cmd      = c;
    item.position = p[POS_BITS-1:0];
    item.value    = v;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      start = 1'b0;
    end
  endtask

  function automatic logic [31:0] pick_word();
    logic [31:0] pool [8];
    pool = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
             32'd5, 32'd7, 32'h0000_ffff, 32'hdead_beef};
    if ($urandom_range(0, 1) == 0) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  initial begin
    int          mode;
    int          left_in_mode;
    int          roll;
    int          pos;
    int          wait_cycles;
    logic [1:0]  c;

    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // directed: empty list, bounds, extremes, duplicates, locate hit and miss
    send_command(CMD_GET,    1,  32'd0);
    send_command(CMD_DELETE, 1,  32'd0);
    send_command(CMD_LOCATE, 0,  32'd0);
    send_command(CMD_INSERT, 0,  32'd1);
    send_command(CMD_INSERT, 2,  32'd1);
    send_command(CMD_INSERT, 1,  32'h8000_0000);
    send_command(CMD_INSERT, 2,  32'h7fff_ffff);
    send_command(CMD_INSERT, 2,  32'hffff_ffff);
    send_command(CMD_INSERT, 1,  32'd5);
    send_command(CMD_INSERT, 2,  32'd5);
    send_command(CMD_LOCATE, 31, 32'd5);
    send_command(CMD_LOCATE, 3,  32'h7fff_ffff);
    send_command(CMD_LOCATE, 1,  32'd12345);
    send_command(CMD_GET,    0,  32'd0);
    send_command(CMD_GET,    5,  32'hffff_ffff);
    send_command(CMD_GET,    6,  32'd0);
    send_command(CMD_DELETE, 6,  32'd0);
    send_command(CMD_DELETE, 2,  32'd0);
    send_command(CMD_DELETE, 4,  32'd0);
    send_command(CMD_INSERT, 31, 32'd9);
    send_command(CMD_GET,    3,  32'h5555_aaaa);

    // random: episodes that fill, drain or churn the list
    mode         = 0;
    left_in_mode = 0;
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      if (left_in_mode == 0) begin
        mode         = $urandom_range(0, 2);
        left_in_mode = $urandom_range(20, 80);
      end
      left_in_mode--;
      roll = $urandom_range(0, 99);
      case (mode)
        0:       c = (roll < 75) ? CMD_INSERT : (roll < 85) ? CMD_LOCATE :
                     (roll < 93) ? CMD_GET : CMD_DELETE;
        1:       c = (roll < 60) ? CMD_DELETE : (roll < 75) ? CMD_INSERT :
                     (roll < 88) ? CMD_GET : CMD_LOCATE;
        default: c = (roll < 35) ? CMD_INSERT : (roll < 60) ? CMD_DELETE :
                     (roll < 80) ? CMD_GET : CMD_LOCATE;
      endcase
      if ($urandom_range(0, 9) == 0)
        pos = $urandom_range(0, 31);
      else if (c == CMD_INSERT)
        pos = $urandom_range(1, seen_len + 1);
      else
        pos = $urandom_range(1, (seen_len > 0) ? seen_len : 1);
      send_command(c, pos, pick_word());
      if (i < RANDOM_CMDS - QUIET_TAIL && $urandom_range(0, 5) == 0)
        hold_off($urandom_range(1, 7));
    end

    @(negedge clk);
    start = 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 100) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (4) @(negedge clk);
    if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
    if (failures == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
design/olid_pkg.sv
design/olid_cell.sv
design/ordered_list_insert_delete.sv
verif/olid_list_checker.sv
verif/tb_ordered_list_insert_delete.sv
